### design/sds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants for the sprite distance sorter: field widths,
// register indexes, controller states and the controller/datapath signals.
// ----------------------------------------------------------------------------
package sds_pkg;

    // Default batch capacity
    localparam int SDS_MAX_SPRITES = 32;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int TEX_W      = 8;
    localparam int IDX_W      = 5;
    localparam int DIST_W     = 33;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SPRITE_W   = 2 * COORD_W + TEX_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;

    // Controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIST,
        ST_SORT_LD,
        ST_SORT_LDW,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_we;    // write incoming sprite at data address
        logic dist_rd;    // read sprite at data address into distance pipe
        logic emit_rd;    // read sprite at current key position
        logic cur_load;   // take key read data as current entry
        logic cmp_en;     // compare key read data against current entry
        logic out_load;   // capture result into output registers
        logic out_final;  // result is the last of the batch
        logic out_ovf;    // batch dropped items
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic dist_busy;  // distance pipeline still holds entries
    } t_dp_status;

endpackage

### design/sprite_distance_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_distance_sorter_top
// Collects a batch of sprites and returns them sorted farthest first by
// squared distance to the camera.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one sprite per transaction,
//   one per cycle while loading. Sprites past MAX_SPRITES are dropped and
//   the batch is marked with overflow. A transaction with batch_end starts
//   the sort; the input stalls until the whole batch has been returned.
//   Output channel (o_out_valid / i_out_stall) returns one sprite per
//   transaction, farthest first, the last one marked with final_result.
//   Camera registers are written through the cfg port while idle.
// Sequence for a batch, counted from the batch end:
//   a distance pass over all sprites, then for each result a compare scan
//   over the entries not yet returned, followed by load and emit. The scan
//   rate is set by the single read port of the key memory, one compare per
//   cycle.
// Receiver stall holds the current result and pauses the sort.
// Reset (synchronous, active low) empties the batch, clears the overflow
// flag and zeroes the camera registers; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module sprite_distance_sorter_top
    import sds_pkg::*;
#(
    parameter int MAX_SPRITES = SDS_MAX_SPRITES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_W-1:0]    i_sprite_x,
    input  logic [COORD_W-1:0]    i_sprite_y,
    input  logic [TEX_W-1:0]      i_texture_id,
    input  logic                  i_batch_end,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_original_index,
    output logic [COORD_W-1:0]    o_out_x,
    output logic [COORD_W-1:0]    o_out_y,
    output logic [TEX_W-1:0]      o_out_texture,
    output logic [DIST_W-1:0]     o_squared_distance,
    output logic                  o_overflow,
    output logic                  o_final_result
);

    localparam int AW = $clog2(MAX_SPRITES);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [AW-1:0] data_addr;
    logic [AW-1:0] key_rd_addr;
    logic [AW-1:0] cmp_addr;

    sds_ctrl #(
        .MAX_SPRITES (MAX_SPRITES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_batch_end   (i_batch_end),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_data_addr   (data_addr),
        .o_key_rd_addr (key_rd_addr),
        .o_cmp_addr    (cmp_addr)
    );

    sds_datapath #(
        .MAX_SPRITES (MAX_SPRITES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_sprite_x         (i_sprite_x),
        .i_sprite_y         (i_sprite_y),
        .i_texture_id       (i_texture_id),
        .i_cmd              (cmd),
        .i_data_addr        (data_addr),
        .i_key_rd_addr      (key_rd_addr),
        .i_cmp_addr         (cmp_addr),
        .o_status           (status),
        .o_original_index   (o_original_index),
        .o_out_x            (o_out_x),
        .o_out_y            (o_out_y),
        .o_out_texture      (o_out_texture),
        .o_squared_distance (o_squared_distance),
        .o_overflow         (o_overflow),
        .o_final_result     (o_final_result)
    );

endmodule

### design/sds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_ctrl
// Sequencer for the sorter: counts loaded sprites, steps the distance pass,
// runs the exchange-sort scans and hands out results one at a time.
// ----------------------------------------------------------------------------
module sds_ctrl
    import sds_pkg::*;
#(
    parameter int MAX_SPRITES = SDS_MAX_SPRITES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_batch_end,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  t_dp_status                     i_status,
    output t_dp_cmd                        o_cmd,
    output logic [$clog2(MAX_SPRITES)-1:0] o_data_addr,
    output logic [$clog2(MAX_SPRITES)-1:0] o_key_rd_addr,
    output logic [$clog2(MAX_SPRITES)-1:0] o_cmp_addr
);

    localparam int AW = $clog2(MAX_SPRITES);
    localparam int CW = $clog2(MAX_SPRITES + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_SPRITES);
    localparam logic [CW-1:0] ONE = CW'(1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_n,     n_n;
    logic [CW-1:0] r_k,     n_k;
    logic [CW-1:0] r_i,     n_i;
    logic [CW-1:0] r_j,     n_j;
    logic [AW-1:0] r_jd,    n_jd;
    logic          r_pend,  n_pend;
    logic          r_drop,  n_drop;

    logic          in_acc;
    logic          last_i;

    assign in_acc = i_in_valid && !o_in_stall;
    assign last_i = ((r_i + ONE) == r_n);

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_jd    <= '0;
            r_pend  <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_n     <= n_n;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            r_jd    <= n_jd;
            r_pend  <= n_pend;
            r_drop  <= n_drop;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_n           = r_n;
        n_k           = r_k;
        n_i           = r_i;
        n_j           = r_j;
        n_jd          = r_jd;
        n_pend        = 1'b0;
        n_drop        = r_drop;
        o_cmd         = '0;
        o_data_addr   = r_count[AW-1:0];
        o_key_rd_addr = r_i[AW-1:0];
        o_cmp_addr    = r_jd;
        o_in_stall    = 1'b1;
        o_out_valid   = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (in_acc) begin
                    // store while room is left, else flag the drop
                    if (r_count < CAP) begin
                        o_cmd.load_we = 1'b1;
                        n_count       = r_count + ONE;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_batch_end) begin
                        n_n     = (r_count < CAP) ? (r_count + ONE) : r_count;
                        n_k     = '0;
                        n_state = ST_DIST;
                    end
                end
            end

            ST_DIST: begin
                // issue one sprite per cycle into the distance pipe
                o_data_addr = r_k[AW-1:0];
                if (r_k != r_n) begin
                    o_cmd.dist_rd = 1'b1;
                    n_k           = r_k + ONE;
                end else if (!i_status.dist_busy) begin
                    n_i     = '0;
                    n_state = ST_SORT_LD;
                end
            end

            ST_SORT_LD: begin
                o_key_rd_addr = r_i[AW-1:0];
                n_state       = ST_SORT_LDW;
            end

            ST_SORT_LDW: begin
                o_cmd.cur_load = 1'b1;
                n_j            = r_i + ONE;
                n_state        = ST_SCAN;
            end

            ST_SCAN: begin
                // read entry j while comparing the one read last cycle
                o_key_rd_addr = r_j[AW-1:0];
                o_cmd.cmp_en  = r_pend;
                if (r_j != r_n) begin
                    n_jd   = r_j[AW-1:0];
                    n_j    = r_j + ONE;
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_state = ST_EMIT_RD;
                end
            end

            ST_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = ST_EMIT_LD;
            end

            ST_EMIT_LD: begin
                o_cmd.out_load  = 1'b1;
                o_cmd.out_final = last_i;
                o_cmd.out_ovf   = r_drop;
                n_state         = ST_OUT;
            end

            ST_OUT: begin
                // hold the result until the receiver takes it
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (last_i) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_i     = r_i + ONE;
                        n_state = ST_SORT_LD;
                    end
                end
            end

            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

### design/sds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_datapath
// Camera registers, sprite and key memories, squared-distance pipeline,
// current-entry register of the exchange sort and output registers.
// ----------------------------------------------------------------------------
module sds_datapath
    import sds_pkg::*;
#(
    parameter int MAX_SPRITES = SDS_MAX_SPRITES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  logic [COORD_W-1:0]             i_sprite_x,
    input  logic [COORD_W-1:0]             i_sprite_y,
    input  logic [TEX_W-1:0]               i_texture_id,
    input  t_dp_cmd                        i_cmd,
    input  logic [$clog2(MAX_SPRITES)-1:0] i_data_addr,
    input  logic [$clog2(MAX_SPRITES)-1:0] i_key_rd_addr,
    input  logic [$clog2(MAX_SPRITES)-1:0] i_cmp_addr,
    output t_dp_status                     o_status,
    output logic [IDX_W-1:0]               o_original_index,
    output logic [COORD_W-1:0]             o_out_x,
    output logic [COORD_W-1:0]             o_out_y,
    output logic [TEX_W-1:0]               o_out_texture,
    output logic [DIST_W-1:0]              o_squared_distance,
    output logic                           o_overflow,
    output logic                           o_final_result
);

    localparam int AW = $clog2(MAX_SPRITES);
    localparam int KW = DIST_W + AW;
    localparam int PW = (AW > IDX_W) ? AW : IDX_W;

    // Camera registers
    logic [COORD_W-1:0] r_cam_x, n_cam_x;
    logic [COORD_W-1:0] r_cam_y, n_cam_y;

    always_comb begin
        n_cam_x = r_cam_x;
        n_cam_y = r_cam_y;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAMERA_X: n_cam_x = i_cfg_data;
                REG_CAMERA_Y: n_cam_y = i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
        end else begin
            r_cam_x <= n_cam_x;
            r_cam_y <= n_cam_y;
        end
    end

    // Sprite memory, indexed by load position
    logic [SPRITE_W-1:0] spr_rdata;
    logic [AW-1:0]       spr_raddr;
    logic [AW-1:0]       r_cur_pos;
    logic [DIST_W-1:0]   r_cur_dist;

    assign spr_raddr = i_cmd.emit_rd ? r_cur_pos : i_data_addr;

    sds_ram #(
        .WIDTH (SPRITE_W),
        .DEPTH (MAX_SPRITES)
    ) u_spr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_data_addr),
        .i_wdata ({i_texture_id, i_sprite_y, i_sprite_x}),
        .i_raddr (spr_raddr),
        .o_rdata (spr_rdata)
    );

    logic [COORD_W-1:0] spr_x;
    logic [COORD_W-1:0] spr_y;
    logic [TEX_W-1:0]   spr_tex;

    assign spr_x   = spr_rdata[COORD_W-1:0];
    assign spr_y   = spr_rdata[2*COORD_W-1:COORD_W];
    assign spr_tex = spr_rdata[SPRITE_W-1:2*COORD_W];

    // Distance pipe: read, square, sum and write key
    logic               r_v1, r_v2;
    logic [AW-1:0]      r_k1, r_k2;
    logic [SQ_W-1:0]    r_sqx, r_sqy;
    logic [COORD_W-1:0] dx, dy;
    logic [DIST_W-1:0]  dist_sum;

    assign dx = (r_cam_x >= spr_x) ? (r_cam_x - spr_x) : (spr_x - r_cam_x);
    assign dy = (r_cam_y >= spr_y) ? (r_cam_y - spr_y) : (spr_y - r_cam_y);
    assign dist_sum = DIST_W'(r_sqx) + DIST_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.dist_rd;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k1  <= i_data_addr;
        r_k2  <= r_k1;
        r_sqx <= SQ_W'(dx) * SQ_W'(dy - dy + dx);
        r_sqy <= SQ_W'(dy) * SQ_W'(dy);
    end

    assign o_status.dist_busy = r_v1 || r_v2;

    // Key memory: {distance, load position}, reordered by the sort
    logic [KW-1:0]     key_rdata;
    logic [KW-1:0]     key_wdata;
    logic [AW-1:0]     key_waddr;
    logic              key_we;
    logic              cmp_swap;
    logic [DIST_W-1:0] rd_dist;

    assign rd_dist   = key_rdata[KW-1:AW];
    assign cmp_swap  = i_cmd.cmp_en && (rd_dist > r_cur_dist);
    assign key_we    = r_v2 || cmp_swap;
    assign key_waddr = r_v2 ? r_k2 : i_cmp_addr;
    assign key_wdata = r_v2 ? {dist_sum, r_k2} : {r_cur_dist, r_cur_pos};

    sds_ram #(
        .WIDTH (KW),
        .DEPTH (MAX_SPRITES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (i_key_rd_addr),
        .o_rdata (key_rdata)
    );

    // Current entry: keep the larger, push the smaller back to slot j
    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_load || cmp_swap) begin
            r_cur_dist <= rd_dist;
            r_cur_pos  <= key_rdata[AW-1:0];
        end
    end

    // Output registers
    logic [PW-1:0]      pos_ext;
    logic [IDX_W-1:0]   r_out_idx;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [TEX_W-1:0]   r_out_tex;
    logic [DIST_W-1:0]  r_out_dist;
    logic               r_out_ovf;
    logic               r_out_final;

    assign pos_ext = PW'(r_cur_pos);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx   <= pos_ext[IDX_W-1:0];
            r_out_x     <= spr_x;
            r_out_y     <= spr_y;
            r_out_tex   <= spr_tex;
            r_out_dist  <= r_cur_dist;
            r_out_ovf   <= i_cmd.out_ovf;
            r_out_final <= i_cmd.out_final;
        end
    end

    assign o_original_index   = r_out_idx;
    assign o_out_x            = r_out_x;
    assign o_out_y            = r_out_y;
    assign o_out_texture      = r_out_tex;
    assign o_squared_distance = r_out_dist;
    assign o_overflow         = r_out_ovf;
    assign o_final_result     = r_out_final;

endmodule

### design/sds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_checker
// Port-level checks on the sorter's handshakes and batch sequencing.
// ----------------------------------------------------------------------------
module sds_checker
    import sds_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  i_batch_end,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [IDX_W-1:0]      o_original_index,
    input logic [DIST_W-1:0]     o_squared_distance,
    input logic                  o_final_result
);

    // No sprite is taken while a result is on offer
    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while result pending");

    // A batch end closes the input until the batch is returned
    a_stall_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_batch_end) |=> o_in_stall)
        else $error("input open after batch end");

    // The final result ends the output burst
    a_idle_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_final_result) |=> !o_out_valid)
        else $error("result offered after final result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_squared_distance) && $stable(o_original_index)
             && $stable(o_final_result)))
        else $error("stalled result changed");

endmodule

bind sprite_distance_sorter_top sds_checker u_sds_checker (.*);
